>>> hdl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// RTD conversion package
// Fixed-point constants of the platinum sensor curve shared by the pipeline.
// ----------------------------------------------------------------------------
package rtd_pkg;

	// Curve coefficients R0*A, R0*B and R0*C with 48 fraction bits.
	localparam logic signed [51:0] KA = 52'sd1100088584393958;
	localparam logic signed [38:0] KB = -39'sd162550516623;
	localparam logic signed [11:0] KC = -12'sd1933;

	// Nominal resistance R0 with 48 fraction bits.
	localparam logic signed [63:0] R0_Q48 = 64'sd1000 <<< 48;

	// Width of the sum right-shift that leaves 16 fraction bits.
	localparam int unsigned SUM_SHIFT = 32;

	localparam int unsigned RES_W = 28;
	localparam int unsigned TEMP_W = 21;

endpackage

>>> hdl/rtd_resistance_to_temperature.sv
// ----------------------------------------------------------------------------
// RTD resistance to temperature converter
// Bisection of the platinum sensor curve, fully pipelined.
// ----------------------------------------------------------------------------
// An item is a resistance in ohms with 16 fraction bits. It is accepted on a
// clock edge where start is high and busy is low; busy stays low, so one item
// may be accepted in every cycle.
// Each item yields one temperature in tenths of a degree with 8 fraction bits
// on temp_tenths, shown for exactly one cycle with done high.
// Every halving of the interval takes seven pipeline stages: the square, the
// cube and the cubic term each pass through a two-stage split multiplier in
// series, and a last stage sums the terms and picks the half. A final
// register forms the output, and the throughput is one item per cycle.
// Reset clears every valid bit, so no result appears until a new item has
// gone through the whole pipeline. The receiver cannot stall; results leave
// in the order in which items were accepted.
// ----------------------------------------------------------------------------
module rtd_resistance_to_temperature #(
	parameter int unsigned HALVINGS = 22,
	parameter int unsigned TEMP_FRAC_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rtd_pkg::RES_W-1:0]          resistance,
	output logic                               done,
	output logic signed [rtd_pkg::TEMP_W-1:0]  temp_tenths
);

	localparam int unsigned TW = TEMP_FRAC_BITS + 10;
	localparam logic signed [TW-1:0] LOW0  = TW'(-64'sd5 <<< TEMP_FRAC_BITS);
	localparam logic signed [TW-1:0] HIGH0 = TW'(64'sd380 <<< TEMP_FRAC_BITS);

	logic                       v_c   [0:HALVINGS];
	logic [rtd_pkg::RES_W-1:0]  tgt_c [0:HALVINGS];
	logic signed [TW-1:0]       low_c [0:HALVINGS];
	logic signed [TW-1:0]       high_c[0:HALVINGS];

	logic signed [TW:0]         fin_sum;
	logic signed [TW+4:0]       fin_x10;

	assign busy      = 1'b0;
	assign v_c[0]    = start & ~busy;
	assign tgt_c[0]  = resistance;
	assign low_c[0]  = LOW0;
	assign high_c[0] = HIGH0;

	for (genvar g = 0; g < HALVINGS; g++) begin : g_step
		rtd_halving #(
			.FRAC(TEMP_FRAC_BITS)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (v_c[g]),
			.target_i(tgt_c[g]),
			.low_i   (low_c[g]),
			.high_i  (high_c[g]),
			.valid_o (v_c[g+1]),
			.target_o(tgt_c[g+1]),
			.low_o   (low_c[g+1]),
			.high_o  (high_c[g+1])
		);
	end

	assign fin_sum = (TW+1)'(low_c[HALVINGS]) + (TW+1)'(high_c[HALVINGS]);
	assign fin_x10 = (TW+5)'(fin_sum) * 5'sd10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_c[HALVINGS];
		end
	end

	always_ff @(posedge clk) begin
		temp_tenths <= rtd_pkg::TEMP_W'(fin_x10 >>> (TEMP_FRAC_BITS - 7));
	end

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_c[HALVINGS] |=> done) else $error("A finished item produced no result.");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_c[HALVINGS])) else $error("A result appeared with no item.");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("The pipeline refused an item.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (temp_tenths >= -21'sd12800 && temp_tenths <= 21'sd972800))
		else $error("The temperature left the bisection span.");

endmodule

>>> hdl/rtd_halving.sv
// ----------------------------------------------------------------------------
// RTD bisection step
// One halving of the temperature interval in seven register stages, built on
// a two-stage multiplier that splits each operand into halves.
// ----------------------------------------------------------------------------
module rtd_halving #(
	parameter int unsigned FRAC = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_i,
	input  logic [rtd_pkg::RES_W-1:0]         target_i,
	input  logic signed [FRAC+9:0]            low_i,
	input  logic signed [FRAC+9:0]            high_i,
	output logic                              valid_o,
	output logic [rtd_pkg::RES_W-1:0]         target_o,
	output logic signed [FRAC+9:0]            low_o,
	output logic signed [FRAC+9:0]            high_o
);

	localparam int unsigned TW  = FRAC + 10;
	localparam int unsigned T2W = FRAC + 19;
	localparam int unsigned T3W = FRAC + 27;
	localparam int unsigned KAW = $bits(rtd_pkg::KA);
	localparam int unsigned KBW = $bits(rtd_pkg::KB);
	localparam int unsigned KCW = $bits(rtd_pkg::KC);

	logic signed [TW:0]          pair_sum;
	logic signed [TW-1:0]        mid_c;
	logic signed [T2W-1:0]       t2_c;
	logic signed [T3W-1:0]       t3_c;
	logic signed [63:0]          pc_c;
	logic signed [63:0]          sum_c;
	logic signed [32:0]          res_c;
	logic                        above_c;

	logic signed [2*TW-1:0]      tt_s2;
	logic signed [TW+KAW-1:0]    pa_s2;
	logic signed [T2W+TW-1:0]    ttt_s4;
	logic signed [T2W+KBW-1:0]   pb_s4;
	logic signed [T3W+KCW-1:0]   pc_s6;

	logic                        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [rtd_pkg::RES_W-1:0]   target_s1, target_s2, target_s3;
	logic [rtd_pkg::RES_W-1:0]   target_s4, target_s5, target_s6;
	logic signed [TW-1:0]        low_s1, low_s2, low_s3, low_s4, low_s5, low_s6;
	logic signed [TW-1:0]        high_s1, high_s2, high_s3, high_s4, high_s5, high_s6;
	logic signed [TW-1:0]        mid_s1, mid_s2, mid_s3, mid_s4, mid_s5, mid_s6;
	logic signed [63:0]          acc_s3, acc_s4, acc_s5, acc_s6;

	assign pair_sum = (TW+1)'(low_i) + (TW+1)'(high_i);
	assign mid_c    = TW'(pair_sum >>> 1);
	assign t2_c     = T2W'(tt_s2 >>> FRAC);
	assign t3_c     = T3W'(ttt_s4 >>> FRAC);
	assign pc_c     = 64'(pc_s6 >>> FRAC);
	assign sum_c    = acc_s6 + pc_c;
	assign res_c    = {sum_c[63], sum_c[63:rtd_pkg::SUM_SHIFT]};
	assign above_c  = res_c > $signed({5'b0, target_s6});

	rtd_mul #(
		.AW(TW),
		.BW(TW)
	) u_mul_tt (
		.clk (clk),
		.a   (mid_c),
		.b   (mid_c),
		.prod(tt_s2)
	);

	rtd_mul #(
		.AW(TW),
		.BW(KAW)
	) u_mul_pa (
		.clk (clk),
		.a   (mid_c),
		.b   (rtd_pkg::KA),
		.prod(pa_s2)
	);

	rtd_mul #(
		.AW(T2W),
		.BW(TW)
	) u_mul_ttt (
		.clk (clk),
		.a   (t2_c),
		.b   (mid_s2),
		.prod(ttt_s4)
	);

	rtd_mul #(
		.AW(T2W),
		.BW(KBW)
	) u_mul_pb (
		.clk (clk),
		.a   (t2_c),
		.b   (rtd_pkg::KB),
		.prod(pb_s4)
	);

	rtd_mul #(
		.AW(T3W),
		.BW(KCW)
	) u_mul_pc (
		.clk (clk),
		.a   (t3_c),
		.b   (rtd_pkg::KC),
		.prod(pc_s6)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_o  <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_o  <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		target_s1 <= target_i;
		low_s1    <= low_i;
		high_s1   <= high_i;
		mid_s1    <= mid_c;

		target_s2 <= target_s1;
		low_s2    <= low_s1;
		high_s2   <= high_s1;
		mid_s2    <= mid_s1;

		target_s3 <= target_s2;
		low_s3    <= low_s2;
		high_s3   <= high_s2;
		mid_s3    <= mid_s2;
		acc_s3    <= rtd_pkg::R0_Q48 + 64'(pa_s2 >>> FRAC);

		target_s4 <= target_s3;
		low_s4    <= low_s3;
		high_s4   <= high_s3;
		mid_s4    <= mid_s3;
		acc_s4    <= acc_s3;

		target_s5 <= target_s4;
		low_s5    <= low_s4;
		high_s5   <= high_s4;
		mid_s5    <= mid_s4;
		acc_s5    <= acc_s4 + 64'(pb_s4 >>> FRAC);

		target_s6 <= target_s5;
		low_s6    <= low_s5;
		high_s6   <= high_s5;
		mid_s6    <= mid_s5;
		acc_s6    <= acc_s5;

		target_o  <= target_s6;
		low_o     <= above_c ? low_s6 : mid_s6;
		high_o    <= above_c ? mid_s6 : high_s6;
	end

endmodule

// ----------------------------------------------------------------------------
// Split signed multiplier
// Four half-width partial products in the first stage, their sum in the second.
// ----------------------------------------------------------------------------
module rtd_mul #(
	parameter int unsigned AW = 34,
	parameter int unsigned BW = 34
) (
	input  logic                      clk,
	input  logic signed [AW-1:0]      a,
	input  logic signed [BW-1:0]      b,
	output logic signed [AW+BW-1:0]   prod
);

	localparam int unsigned AL = AW / 2;
	localparam int unsigned BL = BW / 2;
	localparam int unsigned PW = AW + BW;

	logic signed [AW-AL-1:0]          a_hi;
	logic signed [AL:0]               a_lo;
	logic signed [BW-BL-1:0]          b_hi;
	logic signed [BL:0]               b_lo;

	logic signed [AW-AL+BW-BL-1:0]    hh_s1;
	logic signed [AW-AL+BL:0]         hl_s1;
	logic signed [AL+BW-BL:0]         lh_s1;
	logic signed [AL+BL+1:0]          ll_s1;

	assign a_hi = $signed(a[AW-1:AL]);
	assign a_lo = $signed({1'b0, a[AL-1:0]});
	assign b_hi = $signed(b[BW-1:BL]);
	assign b_lo = $signed({1'b0, b[BL-1:0]});

	always_ff @(posedge clk) begin
		hh_s1 <= a_hi * b_hi;
		hl_s1 <= a_hi * b_lo;
		lh_s1 <= a_lo * b_hi;
		ll_s1 <= a_lo * b_lo;
		prod  <= (PW'(hh_s1) <<< (AL + BL)) + (PW'(hl_s1) <<< AL)
			+ (PW'(lh_s1) <<< BL) + PW'(ll_s1);
	end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// RTD converter testbench
// Drives corner resistance items, then random bursts, into the pipelined
// bisection converter. A bit-exact predictor in the scoreboard works out each
// expected temperature, and every strobed result is checked in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned HALVINGS = 22;
	localparam int unsigned FRAC = 24;
	localparam int unsigned LATENCY = 7 * HALVINGS + 1;

	typedef logic signed [rtd_pkg::TEMP_W-1:0] temp_t;

	int unsigned mismatches = 0;

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	class temp_scoreboard;
		temp_t pending_temps[$];

		function longint curve_ohms(input longint t);
			logic signed [127:0] t2, t3, sum;
			t2 = (128'(t) * 128'(t)) >>> FRAC;
			t3 = (t2 * 128'(t)) >>> FRAC;
			sum = 128'(rtd_pkg::R0_Q48);
			sum += (128'(rtd_pkg::KA) * 128'(t)) >>> FRAC;
			sum += (128'(rtd_pkg::KB) * t2) >>> FRAC;
			sum += (128'(rtd_pkg::KC) * t3) >>> FRAC;
			return longint'(sum >>> rtd_pkg::SUM_SHIFT);
		endfunction

		function temp_t convert(input logic [rtd_pkg::RES_W-1:0] r);
			longint lo, hi, mid;
			lo = -5 * (longint'(1) << FRAC);
			hi = 380 * (longint'(1) << FRAC);
			for (int i = 0; i < HALVINGS; i++) begin
				mid = (lo + hi) >>> 1;
				if (curve_ohms(mid) > longint'(r))
					hi = mid;
				else
					lo = mid;
			end
			return temp_t'(((lo + hi) * 10) >>> (FRAC - 7));
		endfunction

		function void note(input logic [rtd_pkg::RES_W-1:0] r);
			pending_temps.push_back(convert(r));
		endfunction

		function string check(input temp_t got);
			temp_t exp_temp;
			if (pending_temps.size() == 0)
				return $sformatf("unexpected result %0d", got);
			exp_temp = pending_temps.pop_front();
			if (got !== exp_temp)
				return $sformatf("temp_tenths %0d, expected %0d", got, exp_temp);
			return "";
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [rtd_pkg::RES_W-1:0] resistance = '0;
	logic busy;
	logic done;
	temp_t temp_tenths;

	temp_scoreboard sb = new();

	rtd_resistance_to_temperature uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.resistance(resistance),
		.done(done),
		.temp_tenths(temp_tenths)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		string msg;
		if (done) begin
			msg = sb.check(temp_tenths);
			if (msg != "")
				report(msg);
		end
	end

	task automatic send(input logic [rtd_pkg::RES_W-1:0] r);
		start <= 1'b1;
		resistance <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note(r);
	endtask

	task automatic pause(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [rtd_pkg::RES_W-1:0] random_resistance();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k < 7)
			return rtd_pkg::RES_W'($urandom_range(980 << 16, 2400 << 16));
		if (k < 9)
			return rtd_pkg::RES_W'($urandom);
		return rtd_pkg::RES_W'(sb.curve_ohms((longint'($urandom_range(0, 385 << 16)) << 8)
			- (longint'(5) << FRAC)));
	endfunction

	initial begin
		int unsigned burst;
		int unsigned sent;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send('0);
		send('1);
		send(rtd_pkg::RES_W'(1 << 16));
		send(rtd_pkg::RES_W'(sb.curve_ohms(-5 * (longint'(1) << FRAC))));
		send(rtd_pkg::RES_W'(sb.curve_ohms(-5 * (longint'(1) << FRAC)) - 1));
		send(rtd_pkg::RES_W'(sb.curve_ohms(380 * (longint'(1) << FRAC))));
		send(rtd_pkg::RES_W'(sb.curve_ohms(380 * (longint'(1) << FRAC)) + 1));
		send(rtd_pkg::RES_W'(sb.curve_ohms(375 * (longint'(1) << (FRAC - 1)))));
		send(rtd_pkg::RES_W'(sb.curve_ohms(375 * (longint'(1) << (FRAC - 1))) - 1));
		send(rtd_pkg::RES_W'(1000 << 16));
		send(rtd_pkg::RES_W'(4096 << 16));
		send(28'h5555555);
		send(28'hAAAAAAA);
		pause(3);

		sent = 0;
		while (sent < 800) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++)
				send(random_resistance());
			sent += burst;
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 12));
		end
		start <= 1'b0;

		while (sb.pending_temps.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
